// ===== design/modular_exponentiation_defines.svh =====
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// same-cycle implication
`define MX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/modexp_pkg.sv =====
package modexp_pkg;

    localparam int WORD_BITS = 16;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int CNT_BITS  = $clog2(PROD_BITS);
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    typedef logic [WORD_BITS-1:0] t_word;

    localparam logic [1:0] REG_MODULUS  = 2'd0;
    localparam logic [1:0] REG_PUB_EXP  = 2'd1;
    localparam logic [1:0] REG_PRIV_EXP = 2'd2;

    typedef struct packed {
        t_word modulus;
        t_word pub_exp;
        t_word priv_exp;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic mul_acc;
        logic mul_sq;
        logic step;
        logic wr_acc;
        logic wr_sq;
        logic shift;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic exp_zero;
        logic exp_bit;
    } t_dp_stat;

endpackage

// ===== design/modexp_regs.sv =====
module modexp_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [modexp_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [modexp_pkg::DATA_BITS-1:0]    pwdata,
    output logic [modexp_pkg::DATA_BITS-1:0]    prdata,
    output logic                                pready,
    output modexp_pkg::t_cfg                    o_cfg
);
    import modexp_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;
    t_word      w_rd;
    t_word      w_val;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = paddr[3:2];
    assign w_val  = pwdata[WORD_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.modulus  <= t_word'(1);
            r_cfg.pub_exp  <= '0;
            r_cfg.priv_exp <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MODULUS:  r_cfg.modulus  <= w_val;
                REG_PUB_EXP:  r_cfg.pub_exp  <= w_val;
                REG_PRIV_EXP: r_cfg.priv_exp <= w_val;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MODULUS:  w_rd = r_cfg.modulus;
            REG_PUB_EXP:  w_rd = r_cfg.pub_exp;
            REG_PRIV_EXP: w_rd = r_cfg.priv_exp;
            default:      w_rd = '0;
        endcase
    end

    assign prdata = {{(DATA_BITS-WORD_BITS){1'b0}}, w_rd};
    assign o_cfg  = r_cfg;

endmodule

// ===== design/modexp_dp.sv =====
module modexp_dp (
    input  logic                                i_clk,
    input  modexp_pkg::t_cfg                    i_cfg,
    input  logic                                i_cmd,
    input  logic [modexp_pkg::WORD_BITS-1:0]    i_message,
    input  modexp_pkg::t_dp_cmd                 i_dp_cmd,
    output modexp_pkg::t_dp_stat                o_stat,
    output logic [modexp_pkg::WORD_BITS-1:0]    o_result
);
    import modexp_pkg::*;

    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(PROD_BITS - 1);

    t_word                  r_exp;
    t_word                  r_acc;
    t_word                  r_sq;
    t_word                  r_lo;
    logic [PROD_BITS-1:0]   r_prod;
    logic [WORD_BITS:0]     r_rem;
    logic [CNT_BITS-1:0]    r_cnt;

    logic [PROD_BITS-1:0]   w_prod;
    t_word                  w_op_b;
    logic [WORD_BITS:0]     w_shift;
    logic [WORD_BITS:0]     w_mod;
    logic [WORD_BITS:0]     n_rem;
    t_word                  w_red;

    assign w_op_b  = i_dp_cmd.mul_acc ? r_acc : r_sq;
    assign w_prod  = PROD_BITS'(r_sq) * PROD_BITS'(w_op_b);
    assign w_shift = {r_rem[WORD_BITS-1:0], r_prod[PROD_BITS-1]};
    assign w_mod   = {1'b0, i_cfg.modulus};
    assign n_rem   = (w_shift >= w_mod) ? (w_shift - w_mod) : w_shift;
    // zero modulus: keep the low word of the product
    assign w_red   = (i_cfg.modulus == '0) ? r_lo : n_rem[WORD_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_exp  <= i_cmd ? i_cfg.priv_exp : i_cfg.pub_exp;
            r_acc  <= t_word'(1);
            r_prod <= {{WORD_BITS{1'b0}}, i_message};
            r_lo   <= i_message;
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (i_dp_cmd.mul_acc || i_dp_cmd.mul_sq) begin
            r_prod <= w_prod;
            r_lo   <= w_prod[WORD_BITS-1:0];
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (i_dp_cmd.step) begin
            r_prod <= {r_prod[PROD_BITS-2:0], 1'b0};
            r_rem  <= n_rem;
            r_cnt  <= r_cnt + 1'b1;
        end
        if (i_dp_cmd.wr_acc) begin
            r_acc <= w_red;
        end
        if (i_dp_cmd.wr_sq) begin
            r_sq <= w_red;
        end
        if (i_dp_cmd.shift) begin
            r_exp <= {1'b0, r_exp[WORD_BITS-1:1]};
        end
    end

    assign o_stat.div_last = (r_cnt == CNT_LAST);
    assign o_stat.exp_zero = (r_exp == '0);
    assign o_stat.exp_bit  = r_exp[0];
    assign o_result        = r_acc;

endmodule

// ===== design/modexp_ctrl.sv =====
module modexp_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  modexp_pkg::t_dp_stat    i_stat,
    output modexp_pkg::t_dp_cmd     o_dp_cmd,
    output logic                    o_busy,
    output logic                    o_valid
);
    import modexp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BASE,
        S_SEL,
        S_AMUL,
        S_ADIV,
        S_SMUL,
        S_SDIV
    } t_state;

    t_state r_state;
    logic   r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) r_state <= S_BASE;
                end
                S_BASE: begin
                    if (i_stat.div_last) r_state <= S_SEL;
                end
                S_SEL: begin
                    priority if (i_stat.exp_zero) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (i_stat.exp_bit) begin
                        r_state <= S_AMUL;
                    end else begin
                        r_state <= S_SMUL;
                    end
                end
                S_AMUL: r_state <= S_ADIV;
                S_ADIV: begin
                    if (i_stat.div_last) r_state <= S_SMUL;
                end
                S_SMUL: r_state <= S_SDIV;
                S_SDIV: begin
                    if (i_stat.div_last) r_state <= S_SEL;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_dp_cmd         = '0;
        o_dp_cmd.load    = (r_state == S_IDLE) && i_start;
        o_dp_cmd.mul_acc = (r_state == S_AMUL);
        o_dp_cmd.mul_sq  = (r_state == S_SMUL);
        o_dp_cmd.step    = (r_state == S_BASE) || (r_state == S_ADIV) || (r_state == S_SDIV);
        o_dp_cmd.wr_acc  = (r_state == S_ADIV) && i_stat.div_last;
        o_dp_cmd.wr_sq   = ((r_state == S_BASE) || (r_state == S_SDIV)) && i_stat.div_last;
        o_dp_cmd.shift   = (r_state == S_SDIV) && i_stat.div_last;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

// ===== design/modular_exponentiation.sv =====
// A request first reduces the message, then takes one squaring per exponent bit up to the highest set bit
//   and one more modular product per set bit before the result strobe.
// Throughput: one request at a time, set by the bit-serial remainder unit (32 steps
//   per modular product); the next request is taken in the cycle of the strobe.
// Reset: synchronous, active low; modulus 1, exponents 0, controller idle.
// The result strobe lasts one cycle and the receiver cannot stall it.
`include "modular_exponentiation_defines.svh"

module modular_exponentiation (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_cmd,
    input  logic [modexp_pkg::WORD_BITS-1:0]    i_message,
    output logic                                o_busy,
    output logic                                o_valid,
    output logic [modexp_pkg::WORD_BITS-1:0]    o_result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [modexp_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [modexp_pkg::DATA_BITS-1:0]    pwdata,
    output logic [modexp_pkg::DATA_BITS-1:0]    prdata,
    output logic                                pready
);
    import modexp_pkg::*;

    t_cfg     w_cfg;
    t_dp_cmd  w_dp_cmd;
    t_dp_stat w_stat;

    modexp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    modexp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_stat   (w_stat),
        .o_dp_cmd (w_dp_cmd),
        .o_busy   (o_busy),
        .o_valid  (o_valid)
    );

    modexp_dp u_dp (
        .i_clk     (i_clk),
        .i_cfg     (w_cfg),
        .i_cmd     (i_cmd),
        .i_message (i_message),
        .i_dp_cmd  (w_dp_cmd),
        .o_stat    (w_stat),
        .o_result  (o_result)
    );

    `MX_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !o_busy, "strobe while busy")
    `MX_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy, "request not taken")
    `MX_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid, "strobe repeated")
    `MX_ASSERT_IMP(a_reduced, i_clk, i_rst_n, o_valid && (w_cfg.modulus > t_word'(1)), o_result < w_cfg.modulus, "result not reduced")

endmodule
